// ----- sv/lstb_pkg.sv -----
// Shared types and constants for the link state trace buffer.
// No dependencies; imported by every module of the block except lstb_ram.
package lstb_pkg;

	typedef enum logic [1:0] {
		OP_LOG    = 2'd0,
		OP_READ   = 2'd1,
		OP_STATUS = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_LOGGING_ENABLED = 1'b0,
		REG_LINK_NUMBER     = 1'b1
	} cfg_reg_t;

	localparam int CFG_DATA_W = 3;

	localparam logic [5:0] UNKNOWN_STATE = 6'h3F;

	typedef struct packed {
		op_t         operation;
		logic [5:0]  ltssm_state;
		logic        link_is_up;
		logic        data_link_is_up;
		logic [2:0]  speed_code;
		logic [19:0] time_stamp;
		logic [7:0]  entry_index;
	} item_t;

	typedef struct packed {
		logic        was_logged;
		logic [5:0]  entry_state;
		logic        entry_link_up;
		logic        entry_data_link_up;
		logic [2:0]  entry_speed;
		logic [19:0] entry_time;
		logic [5:0]  write_position;
		logic [6:0]  stored_count;
		logic [15:0] overflow_total;
		logic [5:0]  previous_state;
	} result_t;

	// one ring slot, 31 bits
	typedef struct packed {
		logic [19:0] time_stamp;
		logic [2:0]  speed;
		logic        data_link_up;
		logic        link_up;
		logic [5:0]  state;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic accept;
		logic execute;
	} ctl_cmd_t;

	typedef struct packed {
		logic result_busy;
	} ctl_sts_t;

endpackage

// ----- sv/lstb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lstb_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/lstb_ctrl.sv -----
// Sequencer for the trace buffer: accept a word, then execute it once
// the result register is free. Depends on lstb_pkg.
module lstb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lstb_pkg::ctl_sts_t sts,
	output lstb_pkg::ctl_cmd_t cmd
);
	import lstb_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_n    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.result_busy) begin
					cmd.execute = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

// ----- sv/lstb_dp.sv -----
// Datapath: item register, ring RAM, slot valid bits, counters and the
// result register. Depends on lstb_pkg and lstb_ram.
module lstb_dp #(
	parameter int RING_DEPTH    = 64,
	parameter int OVERFLOW_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  lstb_pkg::cfg_reg_t            cfg_index,
	input  logic [lstb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  lstb_pkg::item_t               item,
	input  lstb_pkg::ctl_cmd_t            cmd,
	output lstb_pkg::ctl_sts_t            sts,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lstb_pkg::result_t             result
);
	import lstb_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);

	logic                     enable_q;
	logic [2:0]               link_number_q;
	item_t                    item_s1;
	logic [RING_DEPTH-1:0]    valid_q;
	logic [AW-1:0]            wp_q;
	logic [CW-1:0]            fill_q;
	logic [OVERFLOW_BITS-1:0] ovf_q;
	logic [5:0]               last_q;
	logic                     result_valid_q;

	logic [AW-1:0]            wp_n;
	logic [CW-1:0]            fill_n;
	logic [OVERFLOW_BITS-1:0] ovf_n;
	logic [5:0]               last_n;
	logic [RING_DEPTH-1:0]    valid_n;
	logic                     do_log;
	logic                     idx_ok;
	logic [AW-1:0]            rd_idx;
	entry_t                   wr_entry;
	entry_t                   rd_entry;
	entry_t                   out_entry;
	result_t                  result_n;

	assign rd_idx = item_s1.entry_index[AW-1:0];
	assign idx_ok = 32'(item_s1.entry_index) < RING_DEPTH;

	assign wr_entry.state        = item_s1.ltssm_state;
	assign wr_entry.link_up      = item_s1.link_is_up;
	assign wr_entry.data_link_up = item_s1.data_link_is_up;
	assign wr_entry.speed        = item_s1.speed_code;
	assign wr_entry.time_stamp   = item_s1.time_stamp;

	assign do_log = (item_s1.operation == OP_LOG) && enable_q
		&& ((item_s1.ltssm_state != last_q) || (fill_q == '0));

	// read address is taken from the incoming word, so data is ready in exec
	lstb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (cmd.execute && do_log),
		.wr_addr (wp_q),
		.wr_data (wr_entry),
		.rd_en   (cmd.accept),
		.rd_addr (item.entry_index[AW-1:0]),
		.rd_data (rd_entry)
	);

	always_comb begin
		wp_n    = wp_q;
		fill_n  = fill_q;
		ovf_n   = ovf_q;
		last_n  = last_q;
		valid_n = valid_q;
		out_entry = '0;
		unique case (item_s1.operation)
			OP_LOG: begin
				if (do_log) begin
					valid_n[wp_q] = 1'b1;
					last_n        = item_s1.ltssm_state;
					wp_n = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (fill_q < CW'(RING_DEPTH)) begin
						fill_n = fill_q + 1'b1;
					end else begin
						ovf_n = ovf_q + 1'b1;
					end
				end
			end
			OP_READ: begin
				if (idx_ok && valid_q[rd_idx]) begin
					out_entry = rd_entry;
				end
			end
			OP_STATUS: ;
			OP_CLEAR: begin
				valid_n = '0;
				wp_n    = '0;
				fill_n  = '0;
				ovf_n   = '0;
				last_n  = UNKNOWN_STATE;
			end
			default: ;
		endcase

		result_n.was_logged         = do_log;
		result_n.entry_state        = out_entry.state;
		result_n.entry_link_up      = out_entry.link_up;
		result_n.entry_data_link_up = out_entry.data_link_up;
		result_n.entry_speed        = out_entry.speed;
		result_n.entry_time         = out_entry.time_stamp;
		result_n.write_position     = 6'(32'(wp_n));
		result_n.stored_count       = 7'(32'(fill_n));
		result_n.overflow_total     = 16'(32'(ovf_n));
		result_n.previous_state     = last_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			link_number_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_LOGGING_ENABLED: enable_q      <= cfg_data[0];
				REG_LINK_NUMBER:     link_number_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			wp_q           <= '0;
			fill_q         <= '0;
			ovf_q          <= '0;
			last_q         <= UNKNOWN_STATE;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.execute) begin
				valid_q        <= valid_n;
				wp_q           <= wp_n;
				fill_q         <= fill_n;
				ovf_q          <= ovf_n;
				last_q         <= last_n;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_s1 <= item;
		end
		if (cmd.execute) begin
			result <= result_n;
		end
	end

	assign sts.result_busy = result_valid_q && !result_ready;
	assign result_valid    = result_valid_q;

endmodule

// ----- sv/link_state_trace_buffer.sv -----
// Link state trace buffer, top level: sequencer plus datapath.
// Accept starts the ring read and moves to EXEC; the execute edge sets result valid.
// A new word is accepted only once the current one has executed.
// A waiting result holds execution of the next word, not its acceptance.
// Reset (async, active low) empties the ring via valid bits, zeroes the
// counters, sets previous state to 63, enables logging, link number 0.
module link_state_trace_buffer #(
	parameter int RING_DEPTH    = 64,
	parameter int OVERFLOW_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  lstb_pkg::cfg_reg_t              cfg_index,
	input  logic [lstb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  lstb_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output lstb_pkg::result_t               result
);
	import lstb_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	lstb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lstb_dp #(
		.RING_DEPTH    (RING_DEPTH),
		.OVERFLOW_BITS (OVERFLOW_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- bench/link_state_trace_buffer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for link_state_trace_buffer: directed and random words on
// the item channel, results checked against an in-bench model of the trace ring.
// Depends on lstb_pkg and the RTL of the block only.
module link_state_trace_buffer_tb;
	import lstb_pkg::*;

	localparam int RING_DEPTH    = 64;
	localparam int OVERFLOW_BITS = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_en = 1'b0;
	cfg_reg_t              cfg_index = REG_LOGGING_ENABLED;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	link_state_trace_buffer #(
		.RING_DEPTH(RING_DEPTH),
		.OVERFLOW_BITS(OVERFLOW_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	// trace model state and register copies
	entry_t      ring_copy [RING_DEPTH];
	logic        slot_filled [RING_DEPTH];
	logic [5:0]  head_slot;
	logic [6:0]  fill_level;
	logic [15:0] overwrites;
	logic [5:0]  prior_state;
	logic        trace_enabled;
	logic [2:0]  trace_link;

	item_t   word_backlog [$];
	result_t trace_replies [$];

	int tx_idle_pct = 32;
	int rx_idle_pct = 70;
	bit hold_request = 1'b0;
	bit hold_served = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int words_taken = 0;
	int results_seen = 0;
	int logged_total = 0;
	int clears_total = 0;
	logic [5:0] recent_state = 6'd0;

	function automatic void empty_trace();
		for (int s = 0; s < RING_DEPTH; s++) begin
			ring_copy[s] = '0;
			slot_filled[s] = 1'b0;
		end
		head_slot = '0;
		fill_level = '0;
		overwrites = '0;
		prior_state = UNKNOWN_STATE;
	endfunction

	function automatic result_t apply_to_trace(item_t w);
		result_t r;
		entry_t e;
		r = '0;
		case (w.operation)
			OP_LOG: begin
				if (trace_enabled && (w.ltssm_state != prior_state || fill_level == 0)) begin
					e.state = w.ltssm_state;
					e.link_up = w.link_is_up;
					e.data_link_up = w.data_link_is_up;
					e.speed = w.speed_code;
					e.time_stamp = w.time_stamp;
					ring_copy[head_slot] = e;
					slot_filled[head_slot] = 1'b1;
					prior_state = w.ltssm_state;
					head_slot = head_slot + 6'd1;   // depth 64 wraps naturally
					if (fill_level < RING_DEPTH)
						fill_level = fill_level + 7'd1;
					else
						overwrites = overwrites + 16'd1;
					r.was_logged = 1'b1;
					logged_total++;
				end
			end
			OP_READ: begin
				if (w.entry_index < RING_DEPTH && slot_filled[w.entry_index[5:0]]) begin
					e = ring_copy[w.entry_index[5:0]];
					r.entry_state = e.state;
					r.entry_link_up = e.link_up;
					r.entry_data_link_up = e.data_link_up;
					r.entry_speed = e.speed;
					r.entry_time = e.time_stamp;
				end
			end
			OP_CLEAR: begin
				empty_trace();
				clears_total++;
			end
			default: ;
		endcase
		r.write_position = head_slot;
		r.stored_count = fill_level;
		r.overflow_total = overwrites;
		r.previous_state = prior_state;
		return r;
	endfunction

	function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic item_t log_word(logic [5:0] st, logic lu, logic dl, logic [2:0] sp,
			logic [19:0] ts);
		item_t w;
		w = '0;
		w.operation = OP_LOG;
		w.ltssm_state = st;
		w.link_is_up = lu;
		w.data_link_is_up = dl;
		w.speed_code = sp;
		w.time_stamp = ts;
		return w;
	endfunction

	function automatic item_t plain_word(op_t op, logic [7:0] idx);
		item_t w;
		w = '0;
		w.operation = op;
		w.entry_index = idx;
		return w;
	endfunction

	// mostly logs and reads; clears rare so the ring gets to wrap between them
	function automatic item_t random_word();
		item_t w;
		int pick;
		w.ltssm_state = 6'($urandom_range(63));
		w.link_is_up = 1'($urandom_range(1));
		w.data_link_is_up = 1'($urandom_range(1));
		w.speed_code = 3'($urandom_range(7));
		w.time_stamp = 20'($urandom_range(20'hFFFFF));
		if ($urandom_range(9) == 0)
			w.entry_index = 8'($urandom_range(255, RING_DEPTH));
		else
			w.entry_index = 8'($urandom_range(RING_DEPTH - 1));
		pick = $urandom_range(399);
		if (pick < 3) begin
			w.operation = OP_CLEAR;
		end else if (pick < 220) begin
			w.operation = OP_LOG;
			if ($urandom_range(4) == 0)
				w.ltssm_state = recent_state;
			recent_state = w.ltssm_state;
		end else if (pick < 350) begin
			w.operation = OP_READ;
		end else begin
			w.operation = OP_STATUS;
		end
		return w;
	endfunction

	// sender: next word only once the current one is gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (word_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				item_valid <= 1'b1;
				item <= word_backlog.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else if (hold_request && !hold_served) begin
			hold_left = HOLD_CYCLES;
			hold_served = 1'b1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) begin
			trace_replies.push_back(apply_to_trace(item));
			words_taken++;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (trace_replies.size() == 0) begin
				$display("%0t ns: result with nothing outstanding, actual 0x%0h", $time, result);
				mismatches++;
			end else begin
				want = trace_replies.pop_front();
				check_field("was_logged", want.was_logged, result.was_logged);
				check_field("entry_state", want.entry_state, result.entry_state);
				check_field("entry_link_up", want.entry_link_up, result.entry_link_up);
				check_field("entry_data_link_up", want.entry_data_link_up,
					result.entry_data_link_up);
				check_field("entry_speed", want.entry_speed, result.entry_speed);
				check_field("entry_time", want.entry_time, result.entry_time);
				check_field("write_position", want.write_position, result.write_position);
				check_field("stored_count", want.stored_count, result.stored_count);
				check_field("overflow_total", want.overflow_total, result.overflow_total);
				check_field("previous_state", want.previous_state, result.previous_state);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				trace_replies.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic wait_drained();
		while (word_backlog.size() != 0 || item_valid || trace_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_LOGGING_ENABLED)
			trace_enabled = val[0];
		else
			trace_link = val;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin tx_idle_pct = 32; rx_idle_pct = 70; end
			1: begin tx_idle_pct = 70; rx_idle_pct = 32; end
			default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
		endcase
	endtask

	initial begin : stimulus
		item_t w;
		logic [2:0] link_plan [6];
		int phase_len;
		link_plan = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd7, 3'd0};
		empty_trace();
		trace_enabled = 1'b1;
		trace_link = 3'd0;
		set_idling(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset status, first log of the unknown state, repeat drop,
		// field extremes, out-of-range and cleared reads, clear
		word_backlog.push_back(plain_word(OP_STATUS, 8'd0));
		word_backlog.push_back(log_word(UNKNOWN_STATE, 1'b1, 1'b1, 3'd7, 20'hFFFFF));
		word_backlog.push_back(log_word(UNKNOWN_STATE, 1'b0, 1'b1, 3'd2, 20'h12345));
		word_backlog.push_back(log_word(6'd0, 1'b0, 1'b0, 3'd0, 20'h00000));
		word_backlog.push_back(plain_word(OP_READ, 8'd0));
		word_backlog.push_back(plain_word(OP_READ, 8'd1));
		word_backlog.push_back(plain_word(OP_READ, 8'(RING_DEPTH)));
		word_backlog.push_back(plain_word(OP_READ, 8'd255));
		word_backlog.push_back(plain_word(OP_CLEAR, 8'd0));
		word_backlog.push_back(plain_word(OP_READ, 8'd0));
		word_backlog.push_back(plain_word(OP_STATUS, 8'd0));
		word_backlog.push_back(log_word(6'd5, 1'b1, 1'b0, 3'd4, 20'hA5A5A));
		wait_drained();
		write_reg(REG_LOGGING_ENABLED, 3'd0);
		word_backlog.push_back(log_word(6'd7, 1'b1, 1'b1, 3'd1, 20'h0F0F0));
		word_backlog.push_back(plain_word(OP_READ, 8'd0));
		word_backlog.push_back(plain_word(OP_STATUS, 8'd0));
		wait_drained();
		write_reg(REG_LOGGING_ENABLED, 3'd1);
		write_reg(REG_LINK_NUMBER, 3'd7);

		// walk the whole ring and past it, so every slot holds a word
		for (int i = 0; i < RING_DEPTH + 6; i++) begin
			w = random_word();
			w.operation = OP_LOG;
			w.ltssm_state = 6'(i % 64);
			word_backlog.push_back(w);
		end
		wait_drained();

		// back-pressure: receiver holds off while the sender keeps offering
		set_idling(2);
		for (int i = 0; i < 40; i++)
			word_backlog.push_back(random_word());
		hold_request = 1'b1;
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_LOGGING_ENABLED, (p == 3) ? 3'd0 : 3'd1);
			write_reg(REG_LINK_NUMBER, link_plan[p]);
			set_idling(p / 2);
			phase_len = (p == 3) ? 100 : 220;
			for (int i = 0; i < phase_len; i++)
				word_backlog.push_back(random_word());
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("Run covered %0d words, %0d results checked: %0d stored, %0d clears,",
			words_taken, results_seen, logged_total, clears_total);
		$display("ring wrap, disabled logging, out-of-range reads and a long receiver stall.");
		if (mismatches == 0 && trace_replies.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
